[design/bitmap_run_allocator_macros.svh]
// ----------------------------------------------------------------------------
// bitmap_run_allocator_macros.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BRA_ASSERT_NOW(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bitmap_run_allocator: assertion failed");

// next-cycle implication
`define BRA_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bitmap_run_allocator: assertion failed");

`endif

[design/bra_pkg.sv]
// ----------------------------------------------------------------------------
// bra_pkg
// Types, codes and constants of the bitmap run allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bra_pkg;

  localparam int MAP_BITS_DEF = 4096;
  localparam int WORD_BITS    = 32;
  localparam int LEN_W        = 13;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_ALLOC = 3'd1;
  localparam logic [2:0] MODE_FREE  = 3'd2;
  localparam logic [2:0] MODE_QUERY = 3'd3;
  localparam logic [2:0] MODE_COUNT = 3'd4;

  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_BAD_RANGE = 2'd1;
  localparam logic [1:0] RES_NO_SPACE  = 2'd2;
  localparam logic [1:0] RES_READ_ONLY = 2'd3;

  localparam logic [1:0] REG_BASE     = 2'd0;
  localparam logic [1:0] REG_SIZE     = 2'd1;
  localparam logic [1:0] REG_WRITABLE = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] block_number;
    logic [12:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first_block;
    logic        is_used;
    logic [12:0] free_total;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SWEEP,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_QUERY_RD,
    S_QUERY_LD,
    S_DONE
  } bra_state_t;

  typedef enum logic [2:0] {
    ACT_FINISH,
    ACT_SWEEP,
    ACT_SCAN,
    ACT_MARK,
    ACT_QUERY
  } bra_act_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic sweep;
    logic scan;
    logic mark_wr;
    logic query_ld;
    logic load_out;
  } bra_cmd_t;

  typedef struct packed {
    bra_act_t action;
    logic     sweep_last;
    logic     scan_done;
    logic     scan_hit;
    logic     mark_last;
  } bra_sts_t;

endpackage

[design/bitmap_run_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// First-fit run allocator over a used/free block bitmap with a free counter.
// ----------------------------------------------------------------------------
// Requests come in on in_item (valid/stall), one result per request leaves on
// out_item (valid/stall). Registers region_base (0x0), region_size (0x4) and
// volume_writable (0x8) are written over APB; the user must do so only while
// the block is idle, which the block does not enforce. One request at a time;
// the bitmap memory (MAP_BITS/32 words, one read and one write port) is
// worked on word by word, W being the words in the region (at least one):
//   clear          zeroes every map word, one word per cycle
//   allocate       scans up to W words; on a hit, marks each word of the run
//   free           reads and writes each touched word
//   query          reads one word, count scans all W, rejected requests nothing
// After reset a clearing pass zeroes every map word while in_stall is high. A
// finished result sits in the output register; while out_stall holds it there
// the next request is still accepted and runs up to its result, which then
// waits until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_run_allocator #(
  parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bra_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bra_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bra_pkg::*;

  logic [31:0] base_r, base_nxt;
  logic [12:0] size_r, size_nxt;
  logic        wr_r, wr_nxt;
  logic        cfg_wr;
  bra_cmd_t    cmd;
  bra_sts_t    sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    base_nxt = base_r;
    size_nxt = size_r;
    wr_nxt   = wr_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BASE:     base_nxt = pwdata;
        REG_SIZE:     size_nxt = pwdata[12:0];
        REG_WRITABLE: wr_nxt   = pwdata[0];
        default:      base_nxt = base_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE:     prdata = base_r;
      REG_SIZE:     prdata = 32'(size_r);
      REG_WRITABLE: prdata = 32'(wr_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= '0;
      wr_r   <= 1'b1;
    end else begin
      base_r <= base_nxt;
      size_r <= size_nxt;
      wr_r   <= wr_nxt;
    end
  end

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  bra_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_item         (in_item),
    .region_base     (base_r),
    .region_size     (size_r),
    .volume_writable (wr_r),
    .sts             (sts),
    .out_item        (out_item)
  );

endmodule

[design/bra_datapath.sv]
// ----------------------------------------------------------------------------
// bra_datapath
// Bitmap memory, request decode, word scan, range marking and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_datapath #(
  parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bra_pkg::bra_cmd_t cmd,
  input  bra_pkg::in_item_t in_item,
  input  logic [31:0]       region_base,
  input  logic [12:0]       region_size,
  input  logic              volume_writable,
  output bra_pkg::bra_sts_t sts,
  output bra_pkg::out_item_t out_item
);
  import bra_pkg::*;

  localparam int WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW    = $clog2(MAP_BITS + 1);

  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;

  in_item_t    req_r, req_nxt;
  logic [12:0] fc_r, fc_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] first_r, first_nxt;
  logic        used_r, used_nxt;
  logic [12:0] total_r, total_nxt;
  logic [AW-1:0] swp_r, swp_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic        ridx_done_r, ridx_done_nxt;
  logic        rvalid_r, rvalid_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [SW-1:0] run_r, run_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] lo_r, lo_nxt;
  logic [SW-1:0] hi_r, hi_nxt;
  logic        set_r, set_nxt;
  logic [AW-1:0] midx_r, midx_nxt;
  out_item_t   out_r, out_nxt;

  logic [SW-1:0] size;
  logic [AW-1:0] lastw;
  logic [32:0]   lim, end_f;
  logic          blk_ge;
  logic [31:0]   rel32;
  logic [31:0]   sum_sat;
  bra_act_t      act;
  logic [1:0]    dstat;

  logic [31:0]   vmask, freev, hitv, used_le;
  logic [SW:0]   re [WORD_BITS];
  logic [4:0]    lu, jh;
  logic          have_u, hit_any, is_last;
  logic [5:0]    pop;
  logic [31:0]   start32;

  logic [4:0]    lb, ub;
  logic [31:0]   mmask, mdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  always_comb begin
    if (32'(region_size) > 32'(MAP_BITS)) begin
      size = SW'(MAP_BITS);
    end else begin
      size = SW'(region_size);
    end
  end

  assign lastw   = (size == '0) ? '0 : AW'((size - SW'(1)) >> 5);
  assign lim     = {1'b0, region_base} + 33'(size);
  assign end_f   = {1'b0, req_r.block_number} + 33'(req_r.run_length);
  assign blk_ge  = req_r.block_number >= region_base;
  assign rel32   = req_r.block_number - region_base;
  assign sum_sat = 32'(fc_r) + 32'(req_r.run_length);

  // request decode
  always_comb begin
    act   = ACT_FINISH;
    dstat = RES_OK;
    unique case (req_r.mode)
      MODE_CLEAR: act = ACT_SWEEP;
      MODE_ALLOC: begin
        if (req_r.run_length == '0 || req_r.run_length > fc_r || size == '0) begin
          dstat = RES_NO_SPACE;
        end else if (!volume_writable) begin
          dstat = RES_READ_ONLY;
        end else begin
          act = ACT_SCAN;
        end
      end
      MODE_FREE: begin
        if (req_r.run_length == '0) begin
          dstat = RES_OK;
        end else if (!blk_ge || end_f > lim) begin
          dstat = RES_BAD_RANGE;
        end else if (!volume_writable) begin
          dstat = RES_READ_ONLY;
        end else begin
          act = ACT_MARK;
        end
      end
      MODE_QUERY: begin
        if (blk_ge && {1'b0, req_r.block_number} < lim) begin
          act = ACT_QUERY;
        end
      end
      MODE_COUNT: act = ACT_SCAN;
      default:    dstat = RES_BAD_RANGE;
    endcase
  end

  // one map word of the scan
  always_comb begin
    if (32'(pidx_r) < 32'(size >> 5)) begin
      vmask = '1;
    end else if (32'(pidx_r) == 32'(size >> 5)) begin
      vmask = (32'd1 << size[4:0]) - 32'd1;
    end else begin
      vmask = '0;
    end
    freev = ~rdata_r & vmask;
    for (int j = 0; j < WORD_BITS; j++) begin
      used_le = ~freev & (32'hFFFF_FFFF >> (WORD_BITS - 1 - j));
      have_u  = 1'b0;
      lu      = '0;
      for (int k = 0; k <= j; k++) begin
        if (used_le[k]) begin
          have_u = 1'b1;
          lu     = 5'(k);
        end
      end
      if (have_u) begin
        re[j] = (SW + 1)'(j) - (SW + 1)'(lu);
      end else begin
        re[j] = (SW + 1)'(run_r) + (SW + 1)'(j + 1);
      end
      hitv[j] = freev[j] && (32'(re[j]) >= 32'(req_r.run_length));
    end
    jh = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hitv[j]) begin
        jh = 5'(j);
      end
    end
    hit_any = |hitv;
    pop = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pop = pop + 6'(freev[j]);
    end
    start32 = (32'(pidx_r) << 5) + 32'(jh) + 32'd1 - 32'(req_r.run_length);
  end

  assign is_last = pidx_r == lastw;

  // range mask for the word being marked
  always_comb begin
    lb    = (midx_r == AW'(lo_r >> 5)) ? lo_r[4:0] : 5'd0;
    ub    = (midx_r == AW'(hi_r >> 5)) ? hi_r[4:0] : 5'd31;
    mmask = (32'hFFFF_FFFF << lb) & (32'hFFFF_FFFF >> (5'd31 - ub));
    mdata = set_r ? (rdata_r | mmask) : (rdata_r & ~mmask);
  end

  assign we    = cmd.sweep | cmd.mark_wr;
  assign waddr = cmd.sweep ? swp_r : midx_r;
  assign wdata = cmd.sweep ? '0 : mdata;
  assign raddr = cmd.scan ? ridx_r : midx_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    req_nxt       = req_r;
    fc_nxt        = fc_r;
    status_nxt    = status_r;
    first_nxt     = first_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    swp_nxt       = swp_r;
    ridx_nxt      = ridx_r;
    ridx_done_nxt = ridx_done_r;
    rvalid_nxt    = 1'b0;
    pidx_nxt      = pidx_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    set_nxt       = set_r;
    midx_nxt      = midx_r;
    out_nxt       = out_r;

    if (cmd.capture) begin
      req_nxt = in_item;
    end

    if (cmd.decode) begin
      status_nxt    = dstat;
      first_nxt     = '0;
      used_nxt      = 1'b0;
      lo_nxt        = SW'(rel32);
      hi_nxt        = SW'(rel32 + 32'(req_r.run_length) - 32'd1);
      midx_nxt      = AW'(rel32 >> 5);
      set_nxt       = req_r.mode == MODE_ALLOC;
      ridx_nxt      = '0;
      ridx_done_nxt = 1'b0;
      run_nxt       = '0;
      cnt_nxt       = '0;
      if (act == ACT_SWEEP) begin
        fc_nxt = 13'(size);
      end else if (act == ACT_MARK) begin
        fc_nxt = (sum_sat > 32'(size)) ? 13'(size) : 13'(sum_sat);
      end
    end

    if (cmd.sweep) begin
      swp_nxt = (swp_r == AW'(WORDS - 1)) ? '0 : swp_r + AW'(1);
    end

    if (cmd.scan) begin
      if (!ridx_done_r) begin
        rvalid_nxt = 1'b1;
        pidx_nxt   = ridx_r;
        if (ridx_r == lastw) begin
          ridx_done_nxt = 1'b1;
        end else begin
          ridx_nxt = ridx_r + AW'(1);
        end
      end
      if (rvalid_r) begin
        run_nxt = SW'(re[WORD_BITS - 1]);
        cnt_nxt = cnt_r + SW'(pop);
        if (req_r.mode == MODE_ALLOC) begin
          if (hit_any) begin
            first_nxt = region_base + 32'(SW'(start32));
            fc_nxt    = fc_r - req_r.run_length;
            lo_nxt    = SW'(start32);
            hi_nxt    = SW'((32'(pidx_r) << 5) + 32'(jh));
            midx_nxt  = AW'(SW'(start32) >> 5);
          end else if (is_last) begin
            status_nxt = RES_NO_SPACE;
          end
        end else if (is_last) begin
          total_nxt = 13'(cnt_r + SW'(pop));
        end
      end
    end

    if (cmd.mark_wr) begin
      midx_nxt = midx_r + AW'(1);
    end

    if (cmd.query_ld) begin
      used_nxt = rdata_r[lo_r[4:0]];
    end

    if (cmd.load_out) begin
      out_nxt.status      = status_r;
      out_nxt.first_block = first_r;
      out_nxt.is_used     = used_r;
      out_nxt.free_total  = (req_r.mode == MODE_COUNT) ? total_r : fc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      swp_r       <= '0;
      ridx_done_r <= 1'b0;
      rvalid_r    <= 1'b0;
    end else begin
      fc_r        <= fc_nxt;
      swp_r       <= swp_nxt;
      ridx_done_r <= ridx_done_nxt;
      rvalid_r    <= rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    status_r <= status_nxt;
    first_r  <= first_nxt;
    used_r   <= used_nxt;
    total_r  <= total_nxt;
    ridx_r   <= ridx_nxt;
    pidx_r   <= pidx_nxt;
    run_r    <= run_nxt;
    cnt_r    <= cnt_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    set_r    <= set_nxt;
    midx_r   <= midx_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    sts.action     = act;
    sts.sweep_last = swp_r == AW'(WORDS - 1);
    sts.scan_hit   = rvalid_r && (req_r.mode == MODE_ALLOC) && hit_any;
    sts.scan_done  = rvalid_r && ((req_r.mode == MODE_ALLOC && hit_any) || is_last);
    sts.mark_last  = midx_r == AW'(hi_r >> 5);
  end

  assign out_item = out_r;

endmodule

[design/bra_ctrl.sv]
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer: init and clear sweeps, accept, decode, scan, mark, query, handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  input  bra_pkg::bra_sts_t sts,
  output bra_pkg::bra_cmd_t cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import bra_pkg::*;

  bra_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_load;

  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:     if (sts.sweep_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (sts.action)
          ACT_SWEEP: state_nxt = S_SWEEP;
          ACT_SCAN:  state_nxt = S_SCAN;
          ACT_MARK:  state_nxt = S_MARK_RD;
          ACT_QUERY: state_nxt = S_QUERY_RD;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_SWEEP:    if (sts.sweep_last) state_nxt = S_DONE;
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = sts.scan_hit ? S_MARK_RD : S_DONE;
        end
      end
      S_MARK_RD:  state_nxt = S_MARK_WR;
      S_MARK_WR:  state_nxt = sts.mark_last ? S_DONE : S_MARK_RD;
      S_QUERY_RD: state_nxt = S_QUERY_LD;
      S_QUERY_LD: state_nxt = S_DONE;
      S_DONE:     if (can_load) state_nxt = S_IDLE;
      default:    state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_INIT:     cmd.sweep    = 1'b1;
      S_IDLE:     cmd.capture  = in_valid;
      S_DECODE:   cmd.decode   = 1'b1;
      S_SWEEP:    cmd.sweep    = 1'b1;
      S_SCAN:     cmd.scan     = 1'b1;
      S_MARK_WR:  cmd.mark_wr  = 1'b1;
      S_QUERY_LD: cmd.query_ld = 1'b1;
      S_DONE:     cmd.load_out = can_load;
      default:    cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

[design/bra_checker.sv]
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_run_allocator_macros.svh"

module bra_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bra_pkg::out_item_t out_item
);
  import bra_pkg::*;

  `BRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
  `BRA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `BRA_ASSERT_NOW(a_fail_no_block, clk, rst_n, out_valid && out_item.status != RES_OK, out_item.first_block == '0 && !out_item.is_used)
  `BRA_ASSERT_NOW(a_used_ok, clk, rst_n, out_valid && out_item.is_used, out_item.status == RES_OK && out_item.first_block == '0)

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
